@@ sv/pop_pkg.sv @@
`default_nettype none
package pop_pkg;
    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned COORD_BITS = FIELD_BITS;

    typedef enum logic [2:0] {
        ST_TAKEN     = 3'd0,
        ST_COMMITTED = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_ANSWERED  = 3'd4
    } status_t;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                         opcode;
        logic signed [FIELD_BITS-1:0] coord_x;
        logic signed [FIELD_BITS-1:0] coord_y;
        logic                         polygon_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       obstructed;
        logic [4:0] obstacle_count;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch input item
        logic vtx_write;   // write vertex to store
        logic poly_start;  // load polygon k descriptor
        logic edge_eval;   // evaluate edge
        logic edge_mul;    // multiply stage
        logic edge_cmp;    // compare stage
        logic poly_next;   // advance polygon
        logic finish;      // build result
    } pop_cmd_t;

    typedef struct packed {
        logic is_query;
        logic polys_done;
        logic edges_done;
        logic hit;
    } pop_sts_t;
endpackage
`default_nettype wire

@@ sv/pop_ram.sv @@
`default_nettype none
module pop_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/pop_ctrl.sv @@
`default_nettype none
module pop_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output pop_pkg::pop_cmd_t     cmd,
    input  wire pop_pkg::pop_sts_t sts
);
    import pop_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POLY, S_ISSUE, S_WAIT, S_EVAL, S_MUL, S_CMP, S_NEXT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_query)
                begin
                    state_next = S_POLY;
                end
                else
                begin
                    cmd.vtx_write = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_POLY:
            begin
                if (sts.polys_done || sts.hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.poly_start = 1'b1;
                    state_next     = S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT: state_next = S_EVAL;
            S_EVAL:
            begin
                cmd.edge_eval = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.edge_mul = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                cmd.edge_cmp = 1'b1;
                state_next   = sts.edges_done ? S_NEXT : S_ISSUE;
            end
            S_NEXT:
            begin
                cmd.poly_next = 1'b1;
                state_next    = S_POLY;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DECODE) else $error("item not decoded");
endmodule
`default_nettype wire

@@ sv/pop_dp.sv @@
`default_nettype none
module pop_dp #(
    parameter int unsigned MAX_VERTICES  = 256,
    parameter int unsigned MAX_OBSTACLES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pop_pkg::in_item_t in_item,
    input  wire pop_pkg::pop_cmd_t cmd,
    output pop_pkg::pop_sts_t      sts,
    output pop_pkg::out_item_t     out_item
);
    import pop_pkg::*;

    localparam int unsigned VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned VC = $clog2(MAX_VERTICES + 1);
    localparam int unsigned PA = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int unsigned PC = $clog2(MAX_OBSTACLES + 1);
    localparam int unsigned DW = COORD_BITS + 2;
    localparam int unsigned PW = 2 * DW;

    logic                         opcode_reg, pend_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [PC-1:0] npoly_reg;
    logic [VC-1:0] ncomm_reg, nopen_reg;
    logic [2:0]    status_reg;
    logic          inside_reg, hit_reg;
    logic [PC-1:0] k_reg;
    logic [VA-1:0] base_reg;
    logic [VC-1:0] n_reg, i_reg;
    logic          first_reg;
    logic signed [COORD_BITS-1:0] xi_reg, yi_reg;
    logic signed [DW-1:0] a_reg, b_reg, c_reg, e_reg;
    logic          strad_reg, dpos_reg;
    logic signed [PW-1:0] lhs_reg, rhs_reg;
    logic [VA-1:0] first_idx [MAX_OBSTACLES];
    logic [VC-1:0] total_idx [MAX_OBSTACLES];

    logic [VC:0]   pos;
    logic          full;
    logic [VA-1:0] raddr, waddr;
    logic [COORD_BITS-1:0] rx, ry;
    logic signed [COORD_BITS-1:0] cx, cy;

    assign pos   = {1'b0, ncomm_reg} + {1'b0, nopen_reg};
    assign full  = (npoly_reg >= PC'(MAX_OBSTACLES)) || (pos >= (VC+1)'(MAX_VERTICES));
    assign waddr = pos[VA-1:0];
    assign cx    = in_item.coord_x[COORD_BITS-1:0];
    assign cy    = in_item.coord_y[COORD_BITS-1:0];

    // read the wrap vertex n-1 first, then 0..n-1
    assign raddr = first_reg ? base_reg + VA'(n_reg - VC'(1)) : base_reg + VA'(i_reg);

    pop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_xram (
        .clk(clk), .we(cmd.vtx_write && !full), .waddr(waddr),
        .wdata(px_reg), .raddr(raddr), .rdata(rx)
    );
    pop_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_yram (
        .clk(clk), .we(cmd.vtx_write && !full), .waddr(waddr),
        .wdata(py_reg), .raddr(raddr), .rdata(ry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npoly_reg <= '0;
            ncomm_reg <= '0;
            nopen_reg <= '0;
        end
        else if (cmd.vtx_write)
        begin
            if (full)
            begin
                nopen_reg <= '0;
            end
            else if (!pend_reg)
            begin
                nopen_reg <= nopen_reg + VC'(1);
            end
            else
            begin
                nopen_reg <= '0;
                if (nopen_reg >= VC'(2))
                begin
                    npoly_reg <= npoly_reg + PC'(1);
                    ncomm_reg <= ncomm_reg + nopen_reg + VC'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg <= in_item.opcode;
            pend_reg   <= in_item.polygon_end;
            px_reg     <= cx;
            py_reg     <= cy;
            k_reg      <= '0;
            hit_reg    <= 1'b0;
        end
        if (cmd.vtx_write)
        begin
            if (full)
            begin
                status_reg <= ST_FULL;
            end
            else if (!pend_reg)
            begin
                status_reg <= ST_TAKEN;
            end
            else if (nopen_reg >= VC'(2))
            begin
                status_reg <= ST_COMMITTED;
                first_idx[npoly_reg[PA-1:0]] <= ncomm_reg[VA-1:0];
                total_idx[npoly_reg[PA-1:0]] <= nopen_reg + VC'(1);
            end
            else
            begin
                status_reg <= ST_DROPPED;
            end
            inside_reg <= 1'b0;
        end
        if (cmd.poly_start)
        begin
            base_reg   <= first_idx[k_reg[PA-1:0]];
            n_reg      <= total_idx[k_reg[PA-1:0]];
            i_reg      <= '0;
            first_reg  <= 1'b1;
            inside_reg <= 1'b0;
        end
        if (cmd.edge_eval)
        begin
            // rx/ry is vertex i (or the wrap vertex on the first read)
            xi_reg    <= rx;
            yi_reg    <= ry;
            strad_reg <= (signed'(ry) > py_reg) != (yi_reg > py_reg);
            a_reg     <= DW'(px_reg) - DW'(signed'(rx));
            b_reg     <= DW'(yi_reg) - DW'(signed'(ry));
            c_reg     <= DW'(xi_reg) - DW'(signed'(rx));
            e_reg     <= DW'(py_reg) - DW'(signed'(ry));
            dpos_reg  <= (DW'(yi_reg) - DW'(signed'(ry))) > 0;
        end
        if (cmd.edge_mul)
        begin
            lhs_reg <= PW'(a_reg) * PW'(b_reg);
            rhs_reg <= PW'(c_reg) * PW'(e_reg);
        end
        if (cmd.edge_cmp)
        begin
            if (first_reg)
            begin
                first_reg <= 1'b0;
            end
            else
            begin
                i_reg <= i_reg + VC'(1);
                if (strad_reg && (dpos_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg)))
                begin
                    inside_reg <= !inside_reg;
                end
            end
        end
        if (cmd.poly_next)
        begin
            hit_reg <= inside_reg;
            k_reg   <= k_reg + PC'(1);
        end
        if (cmd.finish)
        begin
            status_reg <= ST_ANSWERED;
            inside_reg <= hit_reg;
        end
    end

    assign sts.is_query   = (opcode_reg == OP_QUERY);
    assign sts.hit        = hit_reg;
    assign sts.polys_done = (k_reg >= npoly_reg);
    assign sts.edges_done = !first_reg && (i_reg == n_reg - VC'(1));

    assign out_item.status         = status_reg;
    assign out_item.obstructed     = inside_reg;
    assign out_item.obstacle_count = 5'(npoly_reg);

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (PC+1)'(npoly_reg) <= (PC+1)'(MAX_OBSTACLES)) else $error("count overflow");
    a_verts: assert property (@(posedge clk) disable iff (!rst_n)
        pos <= (VC+1)'(MAX_VERTICES)) else $error("vertex overflow");
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.vtx_write && pend_reg |=> nopen_reg == '0) else $error("open not cleared");
endmodule
`default_nettype wire

@@ sv/polygon_obstacle_point_test.sv @@
`default_nettype none
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_item  (pop_pkg::in_item_t)
// out     | out | out_valid / out_ready| out_item (pop_pkg::out_item_t)
// A vertex item passes S_IDLE, S_DECODE and S_OUT, then waits in S_OUT for out_ready.
// A query runs S_POLY per polygon tested, S_ISSUE, S_WAIT, S_EVAL, S_MUL, S_CMP per
// vertex read and S_NEXT per polygon; the walk stops after the first polygon that holds the point.
// One item is in flight; in_ready is low until its result is taken.
// Reset clears the counters and the controller state only; vertex RAM contents are undefined until written.
module polygon_obstacle_point_test #(
    parameter int unsigned MAX_VERTICES  = 256,
    parameter int unsigned MAX_OBSTACLES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pop_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output pop_pkg::out_item_t      out_item
);
    import pop_pkg::*;

    pop_cmd_t cmd;
    pop_sts_t sts;

    pop_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    pop_dp #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_OBSTACLES(MAX_OBSTACLES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
        .out_item(out_item)
    );
endmodule
`default_nettype wire
